>>> design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PHASE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LOW     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 8'd3;

  localparam logic [7:0] RST_BIT_PHASE   = 8'd50;
  localparam logic [7:0] RST_EDGE        = 8'd5;
  localparam logic [7:0] RST_ACK_LOW     = 8'd20;
  localparam logic [7:0] RST_ACK_TIMEOUT = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    FN_TICK     = 3'd0,
    FN_START    = 3'd1,
    FN_STOP     = 3'd2,
    FN_WRITE    = 3'd3,
    FN_WAIT_ACK = 3'd4,
    FN_READ     = 3'd5
  } func_t;

  typedef enum logic [17:0] {
    PH_IDLE = 18'h00001,
    PH_S1   = 18'h00002,
    PH_S2   = 18'h00004,
    PH_S3   = 18'h00008,
    PH_P1   = 18'h00010,
    PH_P2   = 18'h00020,
    PH_W1   = 18'h00040,
    PH_W2   = 18'h00080,
    PH_W3   = 18'h00100,
    PH_A1   = 18'h00200,
    PH_A2   = 18'h00400,
    PH_R1   = 18'h00800,
    PH_R2   = 18'h01000,
    PH_R3   = 18'h02000,
    PH_K1   = 18'h04000,
    PH_K2   = 18'h08000,
    PH_N1   = 18'h10000,
    PH_N2   = 18'h20000
  } phase_t;

  typedef struct packed {
    func_t      kind;
    logic [7:0] write_data;
    logic       give_ack;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] read_data;
    logic       cmd_rejected;
  } result_t;

endpackage

>>> design/i2c_master_bit_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// I2C master bit engine: start, stop, write byte, ack wait and read byte
// sequences, advanced one phase tick per item.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tuser: func; tdata: write_data,
//           |     |                    |   give_ack, sda_sample
//   out_    | out | out_tvalid/tready  | tdata: line levels and status
//   cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// One item per clock sustained while out_tready is high; each result is
// registered. An output stall holds the engine and delays the results.
// Reset (rst_n, synchronous) idles the sequencer and loads the register
// defaults. A stalled output holds its result; the two-entry queue keeps
// accepting until full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] write_data, [8] give_ack, [9] sda_sample, [15:10] zero
  input  logic [15:0]                     in_tdata,
  // [2:0] func
  input  logic [2:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] scl_level, [1] sda_release, [2] busy_res, [3] done_res,
  // [4] ack_error, [12:5] read_data, [13] cmd_rejected, [15:14] zero
  output logic [15:0]                     out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_valid;
  i2cm_pkg::item_t   push_item;
  i2cm_pkg::item_t   pop_item;
  i2cm_pkg::result_t res;

  i2cm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_item  (pop_item)
  );

  i2cm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .pop_item   (pop_item),
    .pop        (pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {2'b00, res.cmd_rejected, res.read_data, res.ack_error,
                      res.done_res, res.busy_res, res.sda_release, res.scl_level};

endmodule

>>> design/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input items, decodes the function code and hands them to the queue.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [15:0]     in_tdata,
  input  logic [2:0]      in_tuser,
  output logic            push,
  output i2cm_pkg::item_t push_item,
  input  logic            q_full
);

  i2cm_pkg::func_t kind;

  always_comb begin
    unique case (in_tuser)
      i2cm_pkg::FN_START:    kind = i2cm_pkg::FN_START;
      i2cm_pkg::FN_STOP:     kind = i2cm_pkg::FN_STOP;
      i2cm_pkg::FN_WRITE:    kind = i2cm_pkg::FN_WRITE;
      i2cm_pkg::FN_WAIT_ACK: kind = i2cm_pkg::FN_WAIT_ACK;
      i2cm_pkg::FN_READ:     kind = i2cm_pkg::FN_READ;
      default:               kind = i2cm_pkg::FN_TICK;
    endcase
  end

  assign in_tready            = !q_full;
  assign push                 = in_tvalid && !q_full;
  assign push_item.kind       = kind;
  assign push_item.write_data = in_tdata[7:0];
  assign push_item.give_ack   = in_tdata[8];
  assign push_item.sda_sample = in_tdata[9];

endmodule

>>> design/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// Short FIFO of decoded items between the front and the engine.
// ----------------------------------------------------------------------------
module i2cm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2cm_pkg::item_t push_item,
  output logic            q_full,
  input  logic            pop,
  output logic            q_valid,
  output i2cm_pkg::item_t pop_item
);

  i2cm_pkg::item_t                     mem_r [i2cm_pkg::QDEPTH];
  logic [i2cm_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [i2cm_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [i2cm_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;

  localparam logic [i2cm_pkg::QCNT_W-1:0] FULL_CNT = i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH);
  localparam logic [i2cm_pkg::QPTR_W-1:0] LAST_PTR = i2cm_pkg::QPTR_W'(i2cm_pkg::QDEPTH - 1);

  assign q_full   = (cnt_r == FULL_CNT);
  assign q_valid  = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Phase sequencer: runs one item per step, drives the lines, holds the
// timing registers and the output register.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  i2cm_pkg::item_t                   pop_item,
  output logic                              pop,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output i2cm_pkg::result_t                 out_res
);

  logic [7:0] bit_phase_r, edge_r, ack_low_r, ack_timeout_r;

  i2cm_pkg::phase_t phase_r, phase_nxt;
  logic [3:0] bit_idx_r, bit_idx_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_choice_r, ack_choice_nxt;
  logic       timeout_r, timeout_nxt;

  logic              out_valid_r;
  i2cm_pkg::result_t res_r, res_nxt;

  logic [7:0] half;
  logic [7:0] len;
  logic [7:0] len_eff;
  logic       end_hit;
  logic [8:0] poll_inc;
  logic       fin;
  logic       is_cmd;

  assign cfg_ready  = 1'b1;
  assign pop        = q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_res    = res_r;
  assign is_cmd     = (pop_item.kind != i2cm_pkg::FN_TICK);
  assign half       = {1'b0, bit_phase_r[7:1]};
  assign poll_inc   = {1'b0, poll_r} + 9'd1;

  always_comb begin
    unique case (phase_r)
      i2cm_pkg::PH_S1, i2cm_pkg::PH_S2, i2cm_pkg::PH_S3,
      i2cm_pkg::PH_P1, i2cm_pkg::PH_P2, i2cm_pkg::PH_K2,
      i2cm_pkg::PH_N1, i2cm_pkg::PH_N2:                  len = edge_r;
      i2cm_pkg::PH_W1, i2cm_pkg::PH_W2, i2cm_pkg::PH_W3,
      i2cm_pkg::PH_R1:                                   len = bit_phase_r;
      i2cm_pkg::PH_R2:                                   len = half;
      i2cm_pkg::PH_R3:                                   len = bit_phase_r - half;
      i2cm_pkg::PH_K1:                                   len = ack_low_r;
      default:                                           len = 8'd1;
    endcase
    len_eff = (len == 8'd0) ? 8'd1 : len;
    end_hit = (({1'b0, tick_r} + 9'd1) >= {1'b0, len_eff});
  end

  always_comb begin
    phase_nxt      = phase_r;
    bit_idx_nxt    = bit_idx_r;
    tick_nxt       = tick_r;
    shift_nxt      = shift_r;
    poll_nxt       = poll_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_choice_nxt = ack_choice_r;
    timeout_nxt    = timeout_r;
    fin            = 1'b0;
    res_nxt        = '0;

    if (phase_r != i2cm_pkg::PH_IDLE) begin
      res_nxt.cmd_rejected = is_cmd;
      if (phase_r == i2cm_pkg::PH_A2) begin
        if (!pop_item.sda_sample) begin
          scl_nxt   = 1'b0;
          phase_nxt = i2cm_pkg::PH_IDLE;
          fin       = 1'b1;
        end else if (poll_inc > {1'b0, ack_timeout_r}) begin
          timeout_nxt = 1'b1;
          scl_nxt     = 1'b0;
          sda_nxt     = 1'b0;
          phase_nxt   = i2cm_pkg::PH_P1;
          tick_nxt    = '0;
        end else begin
          poll_nxt = poll_inc[7:0];
        end
      end else if (end_hit) begin
        tick_nxt = '0;
        unique case (phase_r)
          i2cm_pkg::PH_S1: begin
            sda_nxt   = 1'b0;
            phase_nxt = i2cm_pkg::PH_S2;
          end
          i2cm_pkg::PH_S2: begin
            scl_nxt   = 1'b0;
            phase_nxt = i2cm_pkg::PH_S3;
          end
          i2cm_pkg::PH_P1: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            phase_nxt = i2cm_pkg::PH_P2;
          end
          i2cm_pkg::PH_W1, i2cm_pkg::PH_A1, i2cm_pkg::PH_R1: begin
            scl_nxt   = 1'b1;
            phase_nxt = (phase_r == i2cm_pkg::PH_W1) ? i2cm_pkg::PH_W2 :
                        (phase_r == i2cm_pkg::PH_A1) ? i2cm_pkg::PH_A2 :
                                                       i2cm_pkg::PH_R2;
          end
          i2cm_pkg::PH_W2: begin
            scl_nxt   = 1'b0;
            phase_nxt = i2cm_pkg::PH_W3;
          end
          i2cm_pkg::PH_W3: begin
            bit_idx_nxt = bit_idx_r + 4'd1;
            if (bit_idx_nxt >= i2cm_pkg::BITS_PER_BYTE) begin
              phase_nxt = i2cm_pkg::PH_IDLE;
              fin       = 1'b1;
            end else begin
              sda_nxt   = shift_r[7];
              shift_nxt = {shift_r[6:0], 1'b0};
              phase_nxt = i2cm_pkg::PH_W1;
            end
          end
          i2cm_pkg::PH_R2: begin
            shift_nxt = {shift_r[6:0], pop_item.sda_sample};
            phase_nxt = i2cm_pkg::PH_R3;
          end
          i2cm_pkg::PH_R3: begin
            scl_nxt     = 1'b0;
            bit_idx_nxt = bit_idx_r + 4'd1;
            if (bit_idx_nxt < i2cm_pkg::BITS_PER_BYTE) begin
              phase_nxt = i2cm_pkg::PH_R1;
            end else if (ack_choice_r) begin
              sda_nxt   = 1'b0;
              phase_nxt = i2cm_pkg::PH_K1;
            end else begin
              sda_nxt   = 1'b1;
              phase_nxt = i2cm_pkg::PH_N1;
            end
          end
          i2cm_pkg::PH_K1: begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cm_pkg::PH_K2;
          end
          i2cm_pkg::PH_N1: begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cm_pkg::PH_N2;
          end
          i2cm_pkg::PH_K2, i2cm_pkg::PH_N2: begin
            scl_nxt   = 1'b0;
            phase_nxt = i2cm_pkg::PH_IDLE;
            fin       = 1'b1;
          end
          default: begin
            phase_nxt = i2cm_pkg::PH_IDLE;
            fin       = 1'b1;
          end
        endcase
      end else begin
        tick_nxt = tick_r + 8'd1;
      end

      if (fin) begin
        res_nxt.done_res  = 1'b1;
        res_nxt.ack_error = (phase_r == i2cm_pkg::PH_P2) && timeout_r;
        if (phase_r == i2cm_pkg::PH_K2 || phase_r == i2cm_pkg::PH_N2) begin
          res_nxt.read_data = shift_r;
        end
        timeout_nxt = 1'b0;
      end
    end else if (is_cmd) begin
      tick_nxt = '0;
      unique case (pop_item.kind)
        i2cm_pkg::FN_START: begin
          sda_nxt   = 1'b1;
          scl_nxt   = 1'b1;
          phase_nxt = i2cm_pkg::PH_S1;
        end
        i2cm_pkg::FN_STOP: begin
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b0;
          phase_nxt = i2cm_pkg::PH_P1;
        end
        i2cm_pkg::FN_WRITE: begin
          scl_nxt     = 1'b0;
          bit_idx_nxt = '0;
          sda_nxt     = pop_item.write_data[7];
          shift_nxt   = {pop_item.write_data[6:0], 1'b0};
          phase_nxt   = i2cm_pkg::PH_W1;
        end
        i2cm_pkg::FN_WAIT_ACK: begin
          sda_nxt     = 1'b1;
          poll_nxt    = '0;
          timeout_nxt = 1'b0;
          phase_nxt   = i2cm_pkg::PH_A1;
        end
        default: begin
          scl_nxt        = 1'b0;
          sda_nxt        = 1'b1;
          bit_idx_nxt    = '0;
          shift_nxt      = '0;
          ack_choice_nxt = pop_item.give_ack;
          phase_nxt      = i2cm_pkg::PH_R1;
        end
      endcase
    end

    res_nxt.scl_level   = scl_nxt;
    res_nxt.sda_release = sda_nxt;
    res_nxt.busy_res    = (phase_nxt != i2cm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_phase_r   <= i2cm_pkg::RST_BIT_PHASE;
      edge_r        <= i2cm_pkg::RST_EDGE;
      ack_low_r     <= i2cm_pkg::RST_ACK_LOW;
      ack_timeout_r <= i2cm_pkg::RST_ACK_TIMEOUT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        i2cm_pkg::CFG_BIT_PHASE:   bit_phase_r   <= cfg_data;
        i2cm_pkg::CFG_EDGE:        edge_r        <= cfg_data;
        i2cm_pkg::CFG_ACK_LOW:     ack_low_r     <= cfg_data;
        i2cm_pkg::CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cm_pkg::PH_IDLE;
      bit_idx_r    <= '0;
      tick_r       <= '0;
      shift_r      <= '0;
      poll_r       <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_choice_r <= 1'b0;
      timeout_r    <= 1'b0;
    end else if (pop) begin
      phase_r      <= phase_nxt;
      bit_idx_r    <= bit_idx_nxt;
      tick_r       <= tick_nxt;
      shift_r      <= shift_nxt;
      poll_r       <= poll_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ack_choice_r <= ack_choice_nxt;
      timeout_r    <= timeout_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule
